// File: design/trm_pkg.sv
package trm_pkg;

  localparam int TAG_W     = 8;
  localparam int KIND_W    = 4;
  localparam int MODE_W    = 3;
  localparam int WORD_W    = 32;
  localparam int SLOT_W    = 3;
  localparam int ELAPSED_W = 17;
  localparam int TIMEOUT_W = 16;
  localparam int ADDR_W    = 3;

  localparam logic [TAG_W-1:0]     TAG_NONE      = 8'd0;
  localparam logic [TAG_W-1:0]     TAG_FIRST     = 8'd1;
  localparam logic [TAG_W-1:0]     TAG_MAX       = 8'd255;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = '1;

  // register index, taken from paddr[2]
  localparam logic REG_TIMEOUT = 1'b0;

  localparam logic [MODE_W-1:0] MODE_ISSUE    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RESOLVE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ARM      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REGISTER = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CANCEL   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TICK     = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd6;

  localparam logic [KIND_W-1:0] K_TAG        = 4'd0;
  localparam logic [KIND_W-1:0] K_TO_WAITER  = 4'd1;
  localparam logic [KIND_W-1:0] K_TO_ASYNC   = 4'd2;
  localparam logic [KIND_W-1:0] K_STASHED    = 4'd3;
  localparam logic [KIND_W-1:0] K_IGNORED    = 4'd4;
  localparam logic [KIND_W-1:0] K_FROM_STASH = 4'd5;
  localparam logic [KIND_W-1:0] K_ARMED      = 4'd6;
  localparam logic [KIND_W-1:0] K_TIMEOUT    = 4'd7;
  localparam logic [KIND_W-1:0] K_REGISTERED = 4'd8;
  localparam logic [KIND_W-1:0] K_CANCELLED  = 4'd9;
  localparam logic [KIND_W-1:0] K_CLEARED    = 4'd10;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
    logic [WORD_W-1:0] payload;
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic              dropped;
  } res_t;

endpackage

// File: design/tagged_response_matcher.sv
// Issue, clear, untagged and timing-out tick requests answer directly; a tick with no result
// answers nothing. Scans walk the slots one entry at a time, read then compare, through one
// comparator; a resolve that finds the stash full also shifts it down and appends.
// One request in flight; the next request is taken only after the result is registered
// into the output register, which waits while the output is stalled.
// Sync active-high reset: tag counter 1, no wait, slots and stash free, timeout 1000.
module tagged_response_matcher #(
  parameter int PENDING_SLOTS = 8,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic [trm_pkg::MODE_W-1:0]         mode,
  input  logic [trm_pkg::TAG_W-1:0]          tag,
  input  logic [trm_pkg::WORD_W-1:0]         result_word,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic [trm_pkg::KIND_W-1:0]         kind,
  output logic [trm_pkg::TAG_W-1:0]          out_tag,
  output logic [trm_pkg::WORD_W-1:0]         payload,
  output logic                               ok,
  output logic [trm_pkg::SLOT_W-1:0]         slot,
  output logic                               dropped_oldest,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [trm_pkg::ADDR_W-1:0]         paddr,
  input  logic [trm_pkg::WORD_W-1:0]         pwdata,
  output logic [trm_pkg::WORD_W-1:0]         prdata,
  output logic                               pready
);

  localparam int WW = trm_pkg::WORD_W;
  localparam int TW = trm_pkg::TAG_W;
  localparam int PW = (PAYLOAD_WIDTH < WW) ? PAYLOAD_WIDTH : WW;
  localparam int SW = $clog2(PENDING_SLOTS);
  localparam int EW = trm_pkg::ELAPSED_W;
  localparam logic [SW-1:0] IDX_LAST = SW'(PENDING_SLOTS - 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_RD       = 3'd1;
  localparam logic [2:0] S_CMP      = 3'd2;
  localparam logic [2:0] S_SHIFT_RD = 3'd3;
  localparam logic [2:0] S_SHIFT_WR = 3'd4;
  localparam logic [2:0] S_APPEND   = 3'd5;
  localparam logic [2:0] S_EMIT     = 3'd6;

  logic [2:0]                        state;
  logic [trm_pkg::TIMEOUT_W-1:0]     timeout_ticks;
  logic [TW-1:0]                     tag_counter;
  logic [TW-1:0]                     wait_tag;
  logic [EW-1:0]                     wait_elapsed;
  logic [PENDING_SLOTS-1:0]          async_active;
  logic [PENDING_SLOTS-1:0]          stash_valid;

  logic [trm_pkg::MODE_W-1:0]        op;
  logic [TW-1:0]                     cur_tag;
  logic [PW-1:0]                     cur_pay;
  logic [SW-1:0]                     idx;
  logic                              scan_stash;
  logic                              free_found;
  logic [SW-1:0]                     free_idx;
  trm_pkg::res_t                     res;

  logic [TW-1:0]                     amem [PENDING_SLOTS];
  logic [TW+PW-1:0]                  smem [PENDING_SLOTS];
  logic [TW-1:0]                     a_rd;
  logic [TW+PW-1:0]                  s_rd;

  logic                              a_we;
  logic                              s_we;
  logic [SW-1:0]                     s_waddr;
  logic [TW+PW-1:0]                  s_wdata;

  logic                              req_acc;
  logic                              cfg_wr;
  logic [TW-1:0]                     s_rd_tag;
  logic [PW-1:0]                     s_rd_pay;
  logic                              valid_bit;
  logic [TW-1:0]                     cmp_tag;
  logic                              entry_hit;
  logic                              last;
  logic                              free_avail;
  logic [SW-1:0]                     free_sel;
  logic [EW-1:0]                     elapsed_inc;
  logic [TW-1:0]                     tag_counter_next;

  function automatic logic [trm_pkg::SLOT_W-1:0] slot_of(input logic [SW-1:0] i);
    logic [SW+trm_pkg::SLOT_W-1:0] ext;
    ext = (SW + trm_pkg::SLOT_W)'(i);
    return ext[trm_pkg::SLOT_W-1:0];
  endfunction

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;

  always_comb begin
    if (paddr[2] == trm_pkg::REG_TIMEOUT) prdata = WW'(timeout_ticks);
    else                                  prdata = '0;
  end

  // shared tag comparator, fed from either store
  assign s_rd_tag   = s_rd[TW+PW-1:PW];
  assign s_rd_pay   = s_rd[PW-1:0];
  assign valid_bit  = scan_stash ? stash_valid[idx] : async_active[idx];
  assign cmp_tag    = scan_stash ? s_rd_tag : a_rd;
  assign entry_hit  = valid_bit && (cmp_tag == cur_tag);
  assign last       = (idx == IDX_LAST);
  assign free_avail = free_found || !stash_valid[idx];
  assign free_sel   = free_found ? free_idx : idx;

  assign elapsed_inc = (wait_elapsed == trm_pkg::ELAPSED_MAX) ? wait_elapsed
                                                              : wait_elapsed + EW'(1);
  assign tag_counter_next = (tag_counter == trm_pkg::TAG_MAX) ? trm_pkg::TAG_FIRST
                                                              : tag_counter + TW'(1);

  assign a_we = (state == S_CMP) && (op == trm_pkg::MODE_REGISTER) && !async_active[idx];

  always_comb begin
    s_we    = 1'b0;
    s_waddr = idx;
    s_wdata = {cur_tag, cur_pay};
    case (state)
      S_CMP: begin
        if ((op == trm_pkg::MODE_RESOLVE) && scan_stash) begin
          if (entry_hit) begin
            s_we = 1'b1;
          end else if (last && free_avail) begin
            s_we    = 1'b1;
            s_waddr = free_sel;
          end
        end
      end
      S_SHIFT_WR: begin
        s_we    = 1'b1;
        s_waddr = idx - SW'(1);
        s_wdata = s_rd;
      end
      S_APPEND: begin
        s_we    = 1'b1;
        s_waddr = IDX_LAST;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (a_we) amem[idx] <= cur_tag;
    a_rd <= amem[idx];
  end

  always_ff @(posedge clk) begin
    if (s_we) smem[s_waddr] <= s_wdata;
    s_rd <= smem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      timeout_ticks <= trm_pkg::TIMEOUT_RESET;
      tag_counter   <= trm_pkg::TAG_FIRST;
      wait_tag      <= trm_pkg::TAG_NONE;
      wait_elapsed  <= '0;
      async_active  <= '0;
      stash_valid   <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg_wr && (paddr[2] == trm_pkg::REG_TIMEOUT)) begin
        timeout_ticks <= pwdata[trm_pkg::TIMEOUT_W-1:0];
      end
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (req_acc) begin
            op         <= mode;
            cur_tag    <= tag;
            cur_pay    <= result_word[PW-1:0];
            idx        <= '0;
            free_found <= 1'b0;
            scan_stash <= 1'b0;
            res        <= '0;
            case (mode)
              trm_pkg::MODE_ISSUE: begin
                res.kind    <= trm_pkg::K_TAG;
                res.tag     <= tag_counter;
                tag_counter <= tag_counter_next;
                state       <= S_EMIT;
              end
              trm_pkg::MODE_RESOLVE: begin
                if (tag == trm_pkg::TAG_NONE) begin
                  res.kind <= trm_pkg::K_IGNORED;
                  state    <= S_EMIT;
                end else if (wait_tag == tag) begin
                  wait_tag     <= trm_pkg::TAG_NONE;
                  wait_elapsed <= '0;
                  res.kind     <= trm_pkg::K_TO_WAITER;
                  res.tag      <= tag;
                  res.payload  <= WW'(result_word[PW-1:0]);
                  res.ok       <= 1'b1;
                  state        <= S_EMIT;
                end else begin
                  state <= S_RD;
                end
              end
              trm_pkg::MODE_ARM: begin
                if (tag == trm_pkg::TAG_NONE) begin
                  res.kind <= trm_pkg::K_IGNORED;
                  state    <= S_EMIT;
                end else begin
                  scan_stash <= 1'b1;
                  state      <= S_RD;
                end
              end
              trm_pkg::MODE_REGISTER, trm_pkg::MODE_CANCEL: begin
                state <= S_RD;
              end
              trm_pkg::MODE_TICK: begin
                if (wait_tag != trm_pkg::TAG_NONE) begin
                  if (elapsed_inc > EW'(timeout_ticks)) begin
                    res.kind     <= trm_pkg::K_TIMEOUT;
                    res.tag      <= wait_tag;
                    wait_tag     <= trm_pkg::TAG_NONE;
                    wait_elapsed <= '0;
                    state        <= S_EMIT;
                  end else begin
                    wait_elapsed <= elapsed_inc;
                  end
                end
              end
              trm_pkg::MODE_CLEAR: begin
                wait_tag     <= trm_pkg::TAG_NONE;
                wait_elapsed <= '0;
                async_active <= '0;
                stash_valid  <= '0;
                res.kind     <= trm_pkg::K_CLEARED;
                state        <= S_EMIT;
              end
              default: ;
            endcase
          end
        end

        S_RD: state <= S_CMP;

        S_CMP: begin
          state <= S_RD;
          idx   <= idx + SW'(1);
          case (op)
            trm_pkg::MODE_RESOLVE: begin
              if (!scan_stash) begin
                if (entry_hit) begin
                  async_active[idx] <= 1'b0;
                  res.kind    <= trm_pkg::K_TO_ASYNC;
                  res.tag     <= cur_tag;
                  res.payload <= WW'(cur_pay);
                  res.ok      <= 1'b1;
                  res.slot    <= slot_of(idx);
                  state       <= S_EMIT;
                end else if (last) begin
                  scan_stash <= 1'b1;
                  idx        <= '0;
                end
              end else begin
                if (entry_hit) begin
                  res.kind <= trm_pkg::K_STASHED;
                  res.tag  <= cur_tag;
                  state    <= S_EMIT;
                end else begin
                  if (!stash_valid[idx] && !free_found) begin
                    free_found <= 1'b1;
                    free_idx   <= idx;
                  end
                  if (last) begin
                    if (free_avail) begin
                      stash_valid[free_sel] <= 1'b1;
                      res.kind <= trm_pkg::K_STASHED;
                      res.tag  <= cur_tag;
                      state    <= S_EMIT;
                    end else begin
                      // stash full: drop entry 0, move the rest down, append
                      idx   <= SW'(1);
                      state <= S_SHIFT_RD;
                    end
                  end
                end
              end
            end
            trm_pkg::MODE_ARM: begin
              if (entry_hit) begin
                stash_valid[idx] <= 1'b0;
                res.kind    <= trm_pkg::K_FROM_STASH;
                res.tag     <= cur_tag;
                res.payload <= WW'(s_rd_pay);
                state       <= S_EMIT;
              end else if (last) begin
                wait_tag     <= cur_tag;
                wait_elapsed <= '0;
                res.kind     <= trm_pkg::K_ARMED;
                res.tag      <= cur_tag;
                state        <= S_EMIT;
              end
            end
            trm_pkg::MODE_REGISTER: begin
              if (!async_active[idx]) begin
                async_active[idx] <= 1'b1;
                res.kind <= trm_pkg::K_REGISTERED;
                res.tag  <= cur_tag;
                res.ok   <= 1'b1;
                res.slot <= slot_of(idx);
                state    <= S_EMIT;
              end else if (last) begin
                res.kind <= trm_pkg::K_REGISTERED;
                res.tag  <= cur_tag;
                state    <= S_EMIT;
              end
            end
            trm_pkg::MODE_CANCEL: begin
              if (entry_hit) async_active[idx] <= 1'b0;
              if (last) begin
                res.kind <= trm_pkg::K_CANCELLED;
                res.tag  <= cur_tag;
                state    <= S_EMIT;
              end
            end
            default: state <= S_IDLE;
          endcase
        end

        S_SHIFT_RD: state <= S_SHIFT_WR;

        S_SHIFT_WR: begin
          if (last) begin
            state <= S_APPEND;
          end else begin
            idx   <= idx + SW'(1);
            state <= S_SHIFT_RD;
          end
        end

        S_APPEND: begin
          res.kind    <= trm_pkg::K_STASHED;
          res.tag     <= cur_tag;
          res.dropped <= 1'b1;
          state       <= S_EMIT;
        end

        S_EMIT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid      <= 1'b1;
            kind           <= res.kind;
            out_tag        <= res.tag;
            payload        <= res.payload;
            ok             <= res.ok;
            slot           <= res.slot;
            dropped_oldest <= res.dropped;
            state          <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_idle_wait_count: assert property (@(posedge clk) disable iff (rst)
    (wait_tag == trm_pkg::TAG_NONE) |-> (wait_elapsed == '0))
    else $error("elapsed count running with no wait armed");

  a_tag_counter_nonzero: assert property (@(posedge clk) disable iff (rst)
    tag_counter != trm_pkg::TAG_NONE)
    else $error("tag counter reached zero");

  a_shift_only_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT_RD) |-> (&stash_valid))
    else $error("stash shift started with a free entry");

  a_timeout_tagged: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (kind == trm_pkg::K_TIMEOUT)) |-> (out_tag != trm_pkg::TAG_NONE))
    else $error("timeout result for untagged wait");
`endif

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import trm_pkg::*;

  localparam int SLOTS        = 8;
  localparam int DRAIN_CYCLES = 64;   // margin for the worst scan, a resolve with a full stash shift
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 192;
  localparam int HOLD_CYCLES  = 400;

  // mode code the block treats as a no-op
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

  class matcher_scoreboard;
    bit [TAG_W-1:0]     next_tag;
    bit [TAG_W-1:0]     wait_tag;
    bit [ELAPSED_W-1:0] wait_elapsed;
    bit [TIMEOUT_W-1:0] timeout;
    bit [TAG_W-1:0]     async_tag[SLOTS];
    bit                 async_busy[SLOTS];
    bit [TAG_W-1:0]     stash_tag[SLOTS];
    bit [WORD_W-1:0]    stash_word[SLOTS];
    bit                 stash_used[SLOTS];
    res_t               expected_responses[$];
    int errors;
    int requests;
    int responses;
    int evictions;
    int no_slot;
    int timeouts;
    int deliveries;

    function new();
      next_tag = TAG_FIRST;
      timeout  = TIMEOUT_RESET;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Runs one request through the matcher state; returns 1 when it yields a result.
    function bit predict_outcome(logic [MODE_W-1:0] m, logic [TAG_W-1:0] t,
                                 logic [WORD_W-1:0] w, output res_t r);
      bit placed;
      r = '0;
      placed = 1'b0;
      case (m)
        MODE_ISSUE: begin
          r.kind = K_TAG;
          r.tag = next_tag;
          next_tag = (next_tag == TAG_MAX) ? TAG_FIRST : next_tag + 1'b1;
          return 1'b1;
        end
        MODE_RESOLVE: begin
          if (t == TAG_NONE) begin
            r.kind = K_IGNORED;
            return 1'b1;
          end
          r.tag = t;
          if (wait_tag == t) begin
            wait_tag = TAG_NONE;
            wait_elapsed = '0;
            r.kind = K_TO_WAITER;
            r.payload = w;
            r.ok = 1'b1;
            return 1'b1;
          end
          for (int i = 0; i < SLOTS; i++) begin
            if (async_busy[i] && async_tag[i] == t) begin
              async_busy[i] = 1'b0;
              r.kind = K_TO_ASYNC;
              r.payload = w;
              r.ok = 1'b1;
              r.slot = i[SLOT_W-1:0];
              return 1'b1;
            end
          end
          r.kind = K_STASHED;
          // same tag overwrites, else first free entry, else evict entry 0 and shift
          for (int i = 0; i < SLOTS; i++) begin
            if (!placed && stash_used[i] && stash_tag[i] == t) begin
              stash_word[i] = w;
              placed = 1'b1;
            end
          end
          for (int i = 0; i < SLOTS; i++) begin
            if (!placed && !stash_used[i]) begin
              stash_tag[i] = t;
              stash_word[i] = w;
              stash_used[i] = 1'b1;
              placed = 1'b1;
            end
          end
          if (!placed) begin
            for (int i = 0; i < SLOTS - 1; i++) begin
              stash_tag[i] = stash_tag[i+1];
              stash_word[i] = stash_word[i+1];
              stash_used[i] = stash_used[i+1];
            end
            stash_tag[SLOTS-1] = t;
            stash_word[SLOTS-1] = w;
            stash_used[SLOTS-1] = 1'b1;
            r.dropped = 1'b1;
          end
          return 1'b1;
        end
        MODE_ARM: begin
          if (t == TAG_NONE) begin
            r.kind = K_IGNORED;
            return 1'b1;
          end
          r.tag = t;
          for (int i = 0; i < SLOTS; i++) begin
            if (stash_used[i] && stash_tag[i] == t) begin
              stash_used[i] = 1'b0;
              r.kind = K_FROM_STASH;
              r.payload = stash_word[i];
              return 1'b1;
            end
          end
          wait_tag = t;
          wait_elapsed = '0;
          r.kind = K_ARMED;
          return 1'b1;
        end
        MODE_REGISTER: begin
          r.kind = K_REGISTERED;
          r.tag = t;
          for (int i = 0; i < SLOTS; i++) begin
            if (!async_busy[i]) begin
              async_tag[i] = t;
              async_busy[i] = 1'b1;
              r.ok = 1'b1;
              r.slot = i[SLOT_W-1:0];
              return 1'b1;
            end
          end
          return 1'b1;
        end
        MODE_CANCEL: begin
          for (int i = 0; i < SLOTS; i++)
            if (async_busy[i] && async_tag[i] == t) async_busy[i] = 1'b0;
          r.kind = K_CANCELLED;
          r.tag = t;
          return 1'b1;
        end
        MODE_TICK: begin
          if (wait_tag == TAG_NONE) return 1'b0;
          if (wait_elapsed != ELAPSED_MAX) wait_elapsed++;
          if (wait_elapsed > timeout) begin
            r.kind = K_TIMEOUT;
            r.tag = wait_tag;
            wait_tag = TAG_NONE;
            wait_elapsed = '0;
            return 1'b1;
          end
          return 1'b0;
        end
        MODE_CLEAR: begin
          wait_tag = TAG_NONE;
          wait_elapsed = '0;
          for (int i = 0; i < SLOTS; i++) begin
            async_busy[i] = 1'b0;
            stash_used[i] = 1'b0;
          end
          r.kind = K_CLEARED;
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    task note_request(logic [MODE_W-1:0] m, logic [TAG_W-1:0] t, logic [WORD_W-1:0] w);
      res_t r;
      requests++;
      if (predict_outcome(m, t, w, r)) begin
        expected_responses.push_back(r);
        if (r.dropped) evictions++;
        if (r.kind == K_REGISTERED && !r.ok) no_slot++;
        if (r.kind == K_TIMEOUT) timeouts++;
        if (r.ok && r.kind != K_REGISTERED) deliveries++;
      end
    endtask

    task check_response(res_t got);
      res_t want;
      responses++;
      if (expected_responses.size() == 0) begin
        report_mismatch($sformatf("unexpected response kind=%0d tag=%0d payload=%h",
                                  got.kind, got.tag, got.payload));
      end else begin
        want = expected_responses.pop_front();
        if (got !== want)
          report_mismatch($sformatf({"response %0d: got kind=%0d tag=%0d payload=%h ok=%0b ",
                                     "slot=%0d drop=%0b, want kind=%0d tag=%0d payload=%h ",
                                     "ok=%0b slot=%0d drop=%0b"},
                                    responses, got.kind, got.tag, got.payload, got.ok,
                                    got.slot, got.dropped, want.kind, want.tag,
                                    want.payload, want.ok, want.slot, want.dropped));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [MODE_W-1:0]  mode = MODE_ISSUE;
  logic [TAG_W-1:0]   tag = TAG_NONE;
  logic [WORD_W-1:0]  result_word = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic [KIND_W-1:0]  kind;
  logic [TAG_W-1:0]   out_tag;
  logic [WORD_W-1:0]  payload;
  logic               ok;
  logic [SLOT_W-1:0]  slot;
  logic               dropped_oldest;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [WORD_W-1:0]  pwdata = '0;
  logic [WORD_W-1:0]  prdata;
  logic               pready;

  matcher_scoreboard sb;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;

  tagged_response_matcher #(
    .PENDING_SLOTS(SLOTS),
    .PAYLOAD_WIDTH(WORD_W)
  ) u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .mode(mode), .tag(tag), .result_word(result_word),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .kind(kind), .out_tag(out_tag), .payload(payload), .ok(ok), .slot(slot),
    .dropped_oldest(dropped_oldest),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d responses outstanding",
               cycle_count, sb.expected_responses.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // response side: long hold-off when asked, else random stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // older response is checked before the new request is predicted
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall)
        sb.check_response({kind, out_tag, payload, ok, slot, dropped_oldest});
      if (req_valid && !req_stall)
        sb.note_request(mode, tag, result_word);
    end
  end

  task send_request(logic [MODE_W-1:0] m, logic [TAG_W-1:0] t, logic [WORD_W-1:0] w);
    int gap;
    gap = 0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    mode <= m;
    tag <= t;
    result_word <= w;
    do @(posedge clk); while (req_stall);
  endtask

  task send_random(int pool);
    int pick;
    logic [MODE_W-1:0] m;
    logic [TAG_W-1:0] t;
    logic [WORD_W-1:0] w;
    pick = $urandom_range(99);
    if (pick < 20)      m = MODE_ISSUE;
    else if (pick < 48) m = MODE_RESOLVE;
    else if (pick < 60) m = MODE_ARM;
    else if (pick < 70) m = MODE_REGISTER;
    else if (pick < 75) m = MODE_CANCEL;
    else if (pick < 95) m = MODE_TICK;
    else if (pick < 97) m = MODE_CLEAR;
    else                m = MODE_UNUSED;
    // small tag pool so waits, slots and stash entries actually meet
    pick = $urandom_range(99);
    if (pick < 4)       t = TAG_NONE;
    else if (pick < 10) t = TAG_W'($urandom_range(255));
    else                t = TAG_W'($urandom_range(pool, 1));
    pick = $urandom_range(9);
    if (pick == 0)      w = '0;
    else if (pick == 1) w = '1;
    else                w = $urandom;
    send_request(m, t, w);
  endtask

  // wait until the block has nothing left to answer, then let any silent scan finish;
  // the first edge lets the monitor note the last accepted request
  task settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task program_timeout(logic [TIMEOUT_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_TIMEOUT, 2'b00};
    pwdata <= {{(WORD_W-TIMEOUT_W){1'b0}}, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.timeout = v;
    // read back
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[TIMEOUT_W-1:0] !== v)
      sb.report_mismatch($sformatf("timeout readback %0d, wrote %0d",
                                   prdata[TIMEOUT_W-1:0], v));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  int unsigned phase_timeout[PHASES] = '{0, 65535, 3, 1, 5, 2, 0, 7};
  int          phase_pool[PHASES]    = '{12, 6, 24, 10, 8, 16, 5, 255};

  initial begin
    int p;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    program_timeout(16'd1);

    send_request(MODE_ISSUE, TAG_NONE, '0);
    send_request(MODE_RESOLVE, TAG_NONE, '1);           // untagged resolve
    send_request(MODE_ARM, TAG_NONE, '0);               // untagged wait
    send_request(MODE_TICK, TAG_NONE, '0);              // nothing armed
    send_request(MODE_UNUSED, TAG_MAX, '1);
    send_request(MODE_ARM, 8'd5, '0);
    send_request(MODE_TICK, 8'd5, '0);                  // still within timeout
    send_request(MODE_TICK, 8'd5, '0);                  // times out
    send_request(MODE_ARM, 8'd9, '0);
    send_request(MODE_ARM, 8'd3, '0);                   // rearm replaces tag 9
    send_request(MODE_RESOLVE, 8'd3, '1);
    send_request(MODE_RESOLVE, 8'd9, 32'h8000_0001);    // goes to stash
    send_request(MODE_ARM, 8'd9, '0);                   // picked from stash
    for (int i = 0; i < SLOTS + 1; i++)                 // last one finds no slot
      send_request(MODE_REGISTER, TAG_MAX - 8'(i), '0);
    send_request(MODE_RESOLVE, TAG_MAX, 32'hA5A5_5A5A);
    send_request(MODE_CANCEL, 8'd254, '0);
    send_request(MODE_CLEAR, TAG_NONE, '0);
    settle();

    for (p = 0; p < PHASES; p++) begin
      program_timeout(phase_timeout[p][TIMEOUT_W-1:0]);
      idle_pct  = (p % 4 == 1) ? 85 : (p % 4 == 3) ? 11 : 0;
      stall_pct = (p % 4 == 2) ? 85 : (p % 4 == 3) ? 11 : 0;
      if (p == 0) hold_left = HOLD_CYCLES;
      for (int n = 0; n < PHASE_ITEMS; n++) send_random(phase_pool[p]);
      settle();
    end

    $display("Covered %0d requests and %0d responses over %0d timeout settings",
             sb.requests, sb.responses, PHASES + 1);
    $display("Deliveries %0d, timeouts %0d, stash evictions %0d, registrations with no slot %0d",
             sb.deliveries, sb.timeouts, sb.evictions, sb.no_slot);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
